[src/opp_pkg.sv]
package opp_pkg;

    // Field widths fixed by the item format
    localparam int TOKEN_W    = 3;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;
    localparam int REL_TBL_W  = 2 * CFG_DATA_W;

    // Largest value the count fields can show
    localparam int COUNT_MAX  = (1 << COUNT_W) - 1;

    // Precedence relation codes
    localparam logic [1:0] REL_ERROR  = 2'd0;
    localparam logic [1:0] REL_YIELDS = 2'd1;
    localparam logic [1:0] REL_EQUAL  = 2'd2;
    localparam logic [1:0] REL_TAKES  = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_SHIFT   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ACCEPT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REL_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REL_HIGH = 1'b1;

    // Token as classified by the front end
    typedef struct packed {
        logic               start;
        logic               cls_ok;
        logic               is_end;
        logic [TOKEN_W-1:0] tok;
    } t_item;

    // Relation of stack class row to class col; rows 4..7 sit in the upper word
    function automatic logic [1:0] rel_lookup(input logic [REL_TBL_W-1:0] tbl,
                                              input logic [TOKEN_W-1:0]   row,
                                              input logic [TOKEN_W-1:0]   col);
        logic [2*TOKEN_W:0] pos;
        pos = {row, col, 1'b0};
        return tbl[pos +: 2];
    endfunction

endpackage

[src/opp_if.sv]
interface opp_in_if;
    import opp_pkg::*;
    logic               valid;
    logic               ready;
    logic               start_req;
    logic [TOKEN_W-1:0] token;

    modport source (output valid, output start_req, output token, input ready);
    modport sink   (input valid, input start_req, input token, output ready);
endinterface

interface opp_out_if;
    import opp_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  reductions;
    logic [COUNT_W-1:0]  depth;

    modport source (output valid, output status, output reductions, output depth,
                    input ready);
    modport sink   (input valid, input status, input reductions, input depth,
                    output ready);
endinterface

interface opp_cfg_if;
    import opp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/operator_precedence_parser.sv]
// Operator-precedence parser over a stack of terminal classes whose bottom is the end
// marker (class NUM_CLASSES-1). Each input beat carries one token and an optional
// start request that empties the stack first; each token yields exactly one result
// beat: shifted, accepted, error or ignored (after an accept or error, until the next
// start), with the handle reduction count and the stack depth, both saturating at 31.
// The two 64-bit relation words (2 bits per stack-class/token pair: error, yields,
// equal, takes precedence) are written over the configuration channel; the user must
// write them only while the block is idle, which the block itself does not enforce.
// Order of work: a token is registered in the front queue and picked up by the back
// end in its idle state; the back end then does one relation lookup against the token
// per decide step, pops one stack entry per pop step during reductions, and loads the
// result register in its emit step, which a token ignored or accepted at pickup enters
// directly. The back end takes a new token only once the last result is loaded, and
// a result held by a stalled sink holds the back end until it leaves.
// The pop loop is bounded by the single read port of the class stack memory.
module operator_precedence_parser #(
    parameter int STACK_DEPTH = 16,
    parameter int NUM_CLASSES = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    opp_in_if.sink    i_in,
    opp_cfg_if.sink   i_cfg,
    opp_out_if.source o_out
);
    import opp_pkg::*;

    logic [CFG_DATA_W-1:0] r_rel_lo;
    logic [CFG_DATA_W-1:0] r_rel_hi;
    logic                  q_valid;
    logic                  q_ready;
    t_item                 q_item;

    // Relation table registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rel_lo <= '0;
            r_rel_hi <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_REL_LOW:  r_rel_lo <= i_cfg.data;
                REG_REL_HIGH: r_rel_hi <= i_cfg.data;
                default: ;
            endcase
        end
    end

    opp_front #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_ready (q_ready)
    );

    opp_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .NUM_CLASSES (NUM_CLASSES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_ready (q_ready),
        .i_rel_tbl ({r_rel_hi, r_rel_lo}),
        .o_out     (o_out)
    );

endmodule

[src/opp_front.sv]
module opp_front #(
    parameter int NUM_CLASSES = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    opp_in_if.sink         i_in,
    output logic           o_q_valid,
    output opp_pkg::t_item o_q_item,
    input  logic           i_q_ready
);
    import opp_pkg::*;

    localparam logic [TOKEN_W-1:0] END_CLASS = TOKEN_W'(NUM_CLASSES - 1);

    t_item       r_q [2];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_cnt, n_cnt;
    t_item       in_item;
    logic        push, pop;

    // Classify the incoming beat
    always_comb begin
        in_item.start  = i_in.start_req;
        in_item.cls_ok = 32'(i_in.token) < NUM_CLASSES;
        in_item.is_end = i_in.token == END_CLASS;
        in_item.tok    = i_in.token;
    end

    assign i_in.ready = r_cnt != 2'd2;
    assign push       = i_in.valid && i_in.ready;
    assign o_q_valid  = r_cnt != 2'd0;
    assign o_q_item   = r_q[r_rd_ptr];
    assign pop        = o_q_valid && i_q_ready;

    // Advance queue pointers
    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop  ? ~r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Hold queued tokens
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_item;
        end
    end

endmodule

[src/opp_back.sv]
module opp_back #(
    parameter int STACK_DEPTH = 16,
    parameter int NUM_CLASSES = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  opp_pkg::t_item                 i_q_item,
    output logic                           o_q_ready,
    input  logic [opp_pkg::REL_TBL_W-1:0]  i_rel_tbl,
    opp_out_if.source                      o_out
);
    import opp_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam logic [TOKEN_W-1:0] END_CLASS = TOKEN_W'(NUM_CLASSES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_POP,
        S_EMIT
    } t_state;

    t_state              r_state, n_state;
    logic [PW-1:0]       r_sp, n_sp;
    logic [PW-1:0]       r_reds, n_reds;
    logic [TOKEN_W-1:0]  r_top, n_top;
    logic [TOKEN_W-1:0]  r_tok, n_tok;
    logic                r_is_end, n_is_end;
    logic                r_fin, n_fin;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [COUNT_W-1:0]  r_out_reds, n_out_reds;
    logic [COUNT_W-1:0]  r_out_depth, n_out_depth;

    logic [TOKEN_W-1:0]  r_stack [STACK_DEPTH];
    logic [TOKEN_W-1:0]  r_rd;
    logic                mem_we;
    logic [PW-1:0]       sp_m2;

    logic                out_free;
    logic [TOKEN_W-1:0]  top_cls;
    logic [TOKEN_W-1:0]  below_cls;
    logic [1:0]          rel_tok;
    logic [1:0]          rel_pop;
    logic                sp_eff_zero;

    assign out_free    = !r_out_valid || o_out.ready;
    assign o_q_ready   = r_state == S_IDLE;
    assign top_cls     = (r_sp == '0) ? END_CLASS : r_top;
    assign below_cls   = (r_sp == PW'(1)) ? END_CLASS : r_rd;
    assign rel_tok     = rel_lookup(i_rel_tbl, top_cls, r_tok);
    assign rel_pop     = rel_lookup(i_rel_tbl, below_cls, r_top);
    assign sp_eff_zero = i_q_item.start || (r_sp == '0);

    // Sequence one token: classify outcome, reduce handles, shift
    always_comb begin
        n_state      = r_state;
        n_sp         = r_sp;
        n_reds       = r_reds;
        n_top        = r_top;
        n_tok        = r_tok;
        n_is_end     = r_is_end;
        n_fin        = r_fin;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_reds   = r_out_reds;
        n_out_depth  = r_out_depth;
        mem_we       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_tok    = i_q_item.tok;
                    n_is_end = i_q_item.is_end;
                    n_reds   = '0;
                    if (i_q_item.start) begin
                        n_sp  = '0;
                        n_fin = 1'b0;
                    end
                    if (r_fin && !i_q_item.start) begin
                        n_status = ST_IGNORED;
                        n_state  = S_EMIT;
                    end else if (!i_q_item.cls_ok) begin
                        n_status = ST_ERROR;
                        n_fin    = 1'b1;
                        n_state  = S_EMIT;
                    end else if (sp_eff_zero && i_q_item.is_end) begin
                        n_status = ST_ACCEPT;
                        n_fin    = 1'b1;
                        n_state  = S_EMIT;
                    end else begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                if (r_sp == '0 && r_is_end) begin
                    n_status = ST_ACCEPT;
                    n_fin    = 1'b1;
                    n_state  = S_EMIT;
                end else if (rel_tok == REL_YIELDS || rel_tok == REL_EQUAL) begin
                    if (32'(r_sp) >= STACK_DEPTH) begin
                        n_status = ST_ERROR;
                        n_fin    = 1'b1;
                    end else begin
                        mem_we   = 1'b1;
                        n_top    = r_tok;
                        n_sp     = r_sp + PW'(1);
                        n_status = ST_SHIFT;
                    end
                    n_state = S_EMIT;
                end else if (rel_tok != REL_TAKES || r_sp == '0) begin
                    n_status = ST_ERROR;
                    n_fin    = 1'b1;
                    n_state  = S_EMIT;
                end else begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                // Drop the top; stop once the new top yields to it, or fail at the bottom
                n_sp  = r_sp - PW'(1);
                n_top = r_rd;
                if (rel_pop == REL_YIELDS) begin
                    n_reds  = r_reds + PW'(1);
                    n_state = S_DECIDE;
                end else if (r_sp == PW'(1)) begin
                    n_status = ST_ERROR;
                    n_fin    = 1'b1;
                    n_state  = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_reds   = (32'(r_reds) > COUNT_MAX) ? COUNT_W'(COUNT_MAX)
                                                             : COUNT_W'(r_reds);
                    n_out_depth  = (32'(r_sp) > COUNT_MAX) ? COUNT_W'(COUNT_MAX)
                                                           : COUNT_W'(r_sp);
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_fin       <= n_fin;
            r_out_valid <= n_out_valid;
        end
        r_reds       <= n_reds;
        r_top        <= n_top;
        r_tok        <= n_tok;
        r_is_end     <= n_is_end;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_reds   <= n_out_reds;
        r_out_depth  <= n_out_depth;
    end

    // Keep the entry below the top ready for the next pop
    assign sp_m2 = n_sp - PW'(2);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_stack[r_sp[AW-1:0]] <= r_tok;
        end
        r_rd <= r_stack[sp_m2[AW-1:0]];
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out_status;
    assign o_out.reductions = r_out_reds;
    assign o_out.depth      = r_out_depth;

endmodule

[bench/operator_precedence_parser_tb.sv]
module operator_precedence_parser_tb;
    import opp_pkg::*;

    localparam int STACK_DEPTH = 16;
    localparam int NUM_CLASSES = 8;
    localparam int ITEM_TARGET = 1950;
    localparam int QUIET_TAIL  = 150;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 40;

    // Terminal classes of the expression grammar used for well-formed input
    typedef enum logic [TOKEN_W-1:0] {
        T_PLUS, T_MUL, T_ID, T_LPAREN, T_RPAREN, T_MINUS, T_POW, T_END
    } t_term;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  reductions;
        logic [COUNT_W-1:0]  depth;
    } t_outcome;

    // Parser state mirror plus the queue of outcomes still owed by the block
    class parse_scoreboard;
        logic [CFG_DATA_W-1:0] rel_lo;
        logic [CFG_DATA_W-1:0] rel_hi;
        logic [TOKEN_W-1:0]    class_stk [STACK_DEPTH];
        int                    sp;
        bit                    finished;
        int                    errors;
        t_outcome              expected_outcomes [$];

        function new();
            rel_lo   = '0;
            rel_hi   = '0;
            sp       = 0;
            finished = 1'b0;
            errors   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_REL_LOW) begin
                rel_lo = val;
            end else begin
                rel_hi = val;
            end
        endfunction

        function logic [1:0] rel_of(logic [TOKEN_W-1:0] row, logic [TOKEN_W-1:0] col);
            logic [CFG_DATA_W-1:0] word;
            int                    pos;
            word = row[2] ? rel_hi : rel_lo;
            pos  = (int'(row[1:0]) * 8 + int'(col)) * 2;
            return word[pos +: 2];
        endfunction

        function logic [TOKEN_W-1:0] top_entry();
            if (sp == 0) begin
                return T_END;
            end
            return class_stk[sp-1];
        endfunction

        // Advance the parser by one token and queue the outcome it must report
        function logic [STATUS_W-1:0] note_token(bit start, logic [TOKEN_W-1:0] tok);
            t_outcome             want;
            logic [STATUS_W-1:0]  st;
            logic [1:0]           rel;
            logic [TOKEN_W-1:0]   popped;
            int                   reds;
            bit                   found;
            bit                   done;
            reds = 0;
            st   = ST_SHIFT;
            if (start) begin
                sp       = 0;
                finished = 1'b0;
            end
            // Every 3-bit token is a legal class when all eight classes exist
            if (finished) begin
                st = ST_IGNORED;
            end else begin
                done = 1'b0;
                while (!done) begin
                    if (sp == 0 && tok == T_END) begin
                        st   = ST_ACCEPT;
                        done = 1'b1;
                    end else begin
                        rel = rel_of(top_entry(), tok);
                        if (rel == REL_YIELDS || rel == REL_EQUAL) begin
                            if (sp >= STACK_DEPTH) begin
                                st = ST_ERROR;
                            end else begin
                                class_stk[sp] = tok;
                                sp++;
                                st = ST_SHIFT;
                            end
                            done = 1'b1;
                        end else if (rel != REL_TAKES || sp == 0) begin
                            st   = ST_ERROR;
                            done = 1'b1;
                        end else begin
                            // Pop the handle until the new top yields to the last popped
                            found = 1'b0;
                            while (sp > 0 && !found) begin
                                popped = top_entry();
                                sp--;
                                if (rel_of(top_entry(), popped) == REL_YIELDS) begin
                                    found = 1'b1;
                                end
                            end
                            if (!found) begin
                                st   = ST_ERROR;
                                done = 1'b1;
                            end else begin
                                reds++;
                            end
                        end
                    end
                end
                if (st == ST_ACCEPT || st == ST_ERROR) begin
                    finished = 1'b1;
                end
            end
            want.status     = st;
            want.reductions = COUNT_W'((reds > COUNT_MAX) ? COUNT_MAX : reds);
            want.depth      = COUNT_W'((sp > COUNT_MAX) ? COUNT_MAX : sp);
            expected_outcomes = {expected_outcomes, want};
            return st;
        endfunction

        // Compare one result beat against the oldest owed outcome
        function void check_outcome(t_outcome got);
            t_outcome want;
            if (expected_outcomes.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: result beat with no token outstanding: status %0d red %0d depth %0d",
                             $time, got.status, got.reductions, got.depth);
                end
                return;
            end
            want = expected_outcomes.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: mismatch status exp %0d got %0d, red exp %0d got %0d, depth exp %0d got %0d",
                             $time, want.status, got.status, want.reductions, got.reductions,
                             want.depth, got.depth);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    opp_in_if  in_if ();
    opp_out_if out_if ();
    opp_cfg_if cfg_if ();

    operator_precedence_parser #(
        .STACK_DEPTH (STACK_DEPTH),
        .NUM_CLASSES (NUM_CLASSES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    parse_scoreboard   sb;
    int                work_items;
    int                src_idle_pct;
    int                sink_stall_pct;
    int                stall_left;
    int                idle_cycles;
    bit                quiet;
    int                idle_levels [3] = '{0, 8, 35};
    logic [TOKEN_W-1:0] expr_tokens [$];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Operator-precedence relations for + - * ^ id ( ) and the end marker
    function automatic int op_rank(int k);
        if (k == T_PLUS || k == T_MINUS) return 1;
        if (k == T_MUL) return 2;
        if (k == T_POW) return 3;
        return 0;
    endfunction

    function automatic logic [REL_TBL_W-1:0] grammar_table();
        logic [REL_TBL_W-1:0] tbl;
        logic [1:0]           code;
        tbl = '0;
        for (int r = 0; r < 8; r++) begin
            for (int c = 0; c < 8; c++) begin
                code = REL_ERROR;
                if (op_rank(r) != 0) begin
                    if (op_rank(c) != 0) begin
                        // Power is right associative, the rest left associative
                        code = (op_rank(c) > op_rank(r) || (r == T_POW && c == T_POW)) ?
                               REL_YIELDS : REL_TAKES;
                    end else if (c == T_ID || c == T_LPAREN) begin
                        code = REL_YIELDS;
                    end else begin
                        code = REL_TAKES;
                    end
                end else if (r == T_ID || r == T_RPAREN) begin
                    if (c != T_ID && c != T_LPAREN) code = REL_TAKES;
                end else if (r == T_LPAREN) begin
                    if (c == T_RPAREN) begin
                        code = REL_EQUAL;
                    end else if (c != T_END) begin
                        code = REL_YIELDS;
                    end
                end else begin
                    if (c != T_RPAREN && c != T_END) code = REL_YIELDS;
                end
                tbl[(r * 8 + c) * 2 +: 2] = code;
            end
        end
        return tbl;
    endfunction

    // Append one token to the expression being built
    function automatic void add_expr_token(logic [TOKEN_W-1:0] tok);
        expr_tokens = {expr_tokens, tok};
    endfunction

    // Drive one token beat, with an optional idle burst ahead of it
    task automatic push_token(input bit start, input logic [TOKEN_W-1:0] tok);
        int gap;
        @(negedge i_clk);
        quiet = (work_items >= ITEM_TARGET - QUIET_TAIL);
        if (!quiet && $urandom_range(0, 99) < src_idle_pct) begin
            gap = $urandom_range(1, 17);
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid     = 1'b1;
        in_if.start_req = start;
        in_if.token     = tok;
        do @(posedge i_clk); while (!in_if.ready);
        void'(sb.note_token(start, tok));
        work_items++;
    endtask

    // Hold off the sender until every owed result beat has come back
    task automatic drain();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (sb.expected_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = val;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // Stall the result channel in random bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_if.ready = 1'b0;
            stall_left--;
        end else if (!quiet && $urandom_range(0, 99) < sink_stall_pct) begin
            stall_left   = $urandom_range(1, 17) - 1;
            out_if.ready = 1'b0;
        end else begin
            out_if.ready = 1'b1;
        end
    end

    // Check every accepted result beat
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            sb.check_outcome({out_if.status, out_if.reductions, out_if.depth});
        end
    end

    // Abort when no beat moves on any channel for too long
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, sb.expected_outcomes.size());
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [REL_TBL_W-1:0] tbl;
        int                   flavor;
        int                   err_pct;
        int                   phase_end;
        int                   open_cnt;
        int                   ops;
        int                   op_target;
        int                   max_nest;
        int                   idx;
        int                   len;
        bit                   broken;

        sb              = new();
        work_items      = 0;
        stall_left      = 0;
        idle_cycles     = 0;
        quiet           = 1'b0;
        src_idle_pct    = 20;
        sink_stall_pct  = 20;
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.start_req = 1'b0;
        in_if.token     = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = '0;
        cfg_if.data     = '0;
        out_if.ready    = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset table: end marker on empty stack accepts, then tokens are ignored
        push_token(1'b0, T_END);
        push_token(1'b0, T_ID);
        // Relation code error from the all-zero table
        push_token(1'b1, T_PLUS);

        // Takes precedence on an empty stack
        drain();
        write_reg(REG_REL_LOW, '1);
        write_reg(REG_REL_HIGH, '1);
        push_token(1'b1, T_ID);

        // Yields everywhere: fill the stack, end marker shifted above bottom, then overflow
        drain();
        write_reg(REG_REL_LOW, {32{2'b01}});
        write_reg(REG_REL_HIGH, {32{2'b01}});
        for (int i = 0; i <= STACK_DEPTH; i++) begin
            push_token(i == 0, i[TOKEN_W-1:0]);
        end

        // Bottom marker equal to all, others take: handle search runs off the bottom
        drain();
        write_reg(REG_REL_LOW, '1);
        write_reg(REG_REL_HIGH, 64'hAAAA_FFFF_FFFF_FFFF);
        push_token(1'b1, T_PLUS);
        push_token(1'b0, T_MUL);

        // Short well-formed expression with reductions
        drain();
        tbl = grammar_table();
        write_reg(REG_REL_LOW, tbl[CFG_DATA_W-1:0]);
        write_reg(REG_REL_HIGH, tbl[REL_TBL_W-1:CFG_DATA_W]);
        push_token(1'b1, T_ID);
        push_token(1'b0, T_MUL);
        push_token(1'b0, T_ID);
        push_token(1'b0, T_END);

        // Random phases, each under its own relation table
        while (work_items < ITEM_TARGET) begin
            drain();
            src_idle_pct   = idle_levels[$urandom_range(0, 2)];
            sink_stall_pct = idle_levels[$urandom_range(0, 2)];
            flavor         = $urandom_range(0, 9);
            if (flavor < 7) begin
                tbl = grammar_table();
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 3)) begin
                        tbl[$urandom_range(0, 63) * 2 +: 2] = 2'($urandom_range(0, 3));
                    end
                end
            end else if (flavor < 9) begin
                err_pct = $urandom_range(0, 30);
                for (int k = 0; k < 64; k++) begin
                    tbl[k * 2 +: 2] = ($urandom_range(0, 99) < err_pct) ?
                                      REL_ERROR : 2'($urandom_range(1, 3));
                end
            end else begin
                case ($urandom_range(0, 3))
                    0: tbl = '0;
                    1: tbl = '1;
                    2: tbl = {64{2'b01}};
                    default: tbl = {64{2'b10}};
                endcase
            end
            write_reg(REG_REL_LOW, tbl[CFG_DATA_W-1:0]);
            write_reg(REG_REL_HIGH, tbl[REL_TBL_W-1:CFG_DATA_W]);

            phase_end = work_items + $urandom_range(60, 200);
            while (work_items < phase_end && work_items < ITEM_TARGET) begin
                if (flavor < 7 && $urandom_range(0, 9) != 0) begin
                    // Build a random expression, sometimes deeply nested
                    expr_tokens.delete();
                    open_cnt  = 0;
                    ops       = 0;
                    max_nest  = ($urandom_range(0, 9) == 0) ? 12 : $urandom_range(0, 3);
                    op_target = ($urandom_range(0, 9) == 0) ? 14 : $urandom_range(0, 6);
                    while (1) begin
                        while (open_cnt < max_nest && $urandom_range(0, 2) == 0) begin
                            add_expr_token(T_LPAREN);
                            open_cnt++;
                        end
                        add_expr_token(T_ID);
                        while (open_cnt > 0 && $urandom_range(0, 2) == 0) begin
                            add_expr_token(T_RPAREN);
                            open_cnt--;
                        end
                        if (ops == op_target) break;
                        case ($urandom_range(0, 3))
                            0: add_expr_token(T_PLUS);
                            1: add_expr_token(T_MINUS);
                            2: add_expr_token(T_MUL);
                            default: add_expr_token(T_POW);
                        endcase
                        ops++;
                    end
                    while (open_cnt > 0) begin
                        add_expr_token(T_RPAREN);
                        open_cnt--;
                    end
                    add_expr_token(T_END);

                    // Corrupt some sequences: drop or replace one token
                    broken = ($urandom_range(0, 5) == 0);
                    if (broken) begin
                        idx = $urandom_range(0, expr_tokens.size() - 1);
                        if (expr_tokens.size() > 1 && $urandom_range(0, 1) == 0) begin
                            expr_tokens.delete(idx);
                        end else begin
                            expr_tokens[idx] = TOKEN_W'($urandom_range(0, 7));
                        end
                    end
                    foreach (expr_tokens[k]) begin
                        push_token(k == 0 || (broken && $urandom_range(0, 24) == 0),
                                   expr_tokens[k]);
                    end
                    if ($urandom_range(0, 39) == 0) begin
                        drain();
                    end
                end else begin
                    // Noise: random tokens with scattered start requests
                    len = $urandom_range(1, 16);
                    for (int k = 0; k < len; k++) begin
                        push_token((k == 0) ? ($urandom_range(0, 9) < 7) :
                                              ($urandom_range(0, 19) == 0),
                                   TOKEN_W'($urandom_range(0, 7)));
                    end
                end
            end
        end

        // Let the last results drain, then settle
        drain();
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_outcomes.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[sim.f]
src/opp_pkg.sv
src/opp_if.sv
src/opp_front.sv
src/opp_back.sv
src/operator_precedence_parser.sv
bench/operator_precedence_parser_tb.sv
